// ===== rtl/shtm_pkg.sv =====
// ----------------------------------------------------------------------------
// shtm_pkg
// Shared types and codes for the two-wire humidity/temperature sensor master.
// ----------------------------------------------------------------------------
package shtm_pkg;

  // request codes carried with each input beat
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_TEMP   = 2'd1;
  localparam logic [1:0] FUNC_HUMID  = 2'd2;
  localparam logic [1:0] FUNC_REINIT = 2'd3;

  // completion status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_ACK  = 2'd1;
  localparam logic [1:0] STAT_TIMEOUT = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_TEMP_CMD      = 3'd0;
  localparam logic [2:0] REG_HUMID_CMD     = 3'd1;
  localparam logic [2:0] REG_SOFT_RST_CMD  = 3'd2;
  localparam logic [2:0] REG_TICKS_PER_MS  = 3'd3;
  localparam logic [2:0] REG_TEMP_WAIT     = 3'd4;
  localparam logic [2:0] REG_HUMID_WAIT    = 3'd5;
  localparam logic [2:0] REG_POLL_INTERVAL = 3'd6;
  localparam logic [2:0] REG_POLL_LIMIT    = 3'd7;

  // configuration reset values
  localparam logic [4:0]  RST_TEMP_CMD      = 5'd3;
  localparam logic [4:0]  RST_HUMID_CMD     = 5'd5;
  localparam logic [4:0]  RST_SOFT_RST_CMD  = 5'd30;
  localparam logic [15:0] RST_TICKS_PER_MS  = 16'd100;
  localparam logic [7:0]  RST_TEMP_WAIT     = 8'd210;
  localparam logic [7:0]  RST_HUMID_WAIT    = 8'd55;
  localparam logic [7:0]  RST_POLL_INTERVAL = 8'd4;
  localparam logic [7:0]  RST_POLL_LIMIT    = 8'd128;

  typedef struct packed {
    logic [4:0]  temp_command;
    logic [4:0]  humid_command;
    logic [4:0]  soft_reset_command;
    logic [15:0] ticks_per_ms;
    logic [7:0]  temp_wait_ms;
    logic [7:0]  humid_wait_ms;
    logic [7:0]  poll_interval_ms;
    logic [7:0]  poll_limit;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] value;
    logic        done_res;
    logic        busy_res;
    logic        data_release;
    logic        clock_level;
  } result_t;

endpackage

// ===== rtl/shtm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// shtm_cfg_regs
// Configuration register bank, written through a valid/ready index port.
// ----------------------------------------------------------------------------
module shtm_cfg_regs (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output shtm_pkg::cfg_t     cfg
);

  shtm_pkg::cfg_t cfg_r;
  shtm_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        shtm_pkg::REG_TEMP_CMD:      cfg_nxt.temp_command       = cfg_data[4:0];
        shtm_pkg::REG_HUMID_CMD:     cfg_nxt.humid_command      = cfg_data[4:0];
        shtm_pkg::REG_SOFT_RST_CMD:  cfg_nxt.soft_reset_command = cfg_data[4:0];
        shtm_pkg::REG_TICKS_PER_MS:  cfg_nxt.ticks_per_ms       = cfg_data;
        shtm_pkg::REG_TEMP_WAIT:     cfg_nxt.temp_wait_ms       = cfg_data[7:0];
        shtm_pkg::REG_HUMID_WAIT:    cfg_nxt.humid_wait_ms      = cfg_data[7:0];
        shtm_pkg::REG_POLL_INTERVAL: cfg_nxt.poll_interval_ms   = cfg_data[7:0];
        shtm_pkg::REG_POLL_LIMIT:    cfg_nxt.poll_limit         = cfg_data[7:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_command       <= shtm_pkg::RST_TEMP_CMD;
      cfg_r.humid_command      <= shtm_pkg::RST_HUMID_CMD;
      cfg_r.soft_reset_command <= shtm_pkg::RST_SOFT_RST_CMD;
      cfg_r.ticks_per_ms       <= shtm_pkg::RST_TICKS_PER_MS;
      cfg_r.temp_wait_ms       <= shtm_pkg::RST_TEMP_WAIT;
      cfg_r.humid_wait_ms      <= shtm_pkg::RST_HUMID_WAIT;
      cfg_r.poll_interval_ms   <= shtm_pkg::RST_POLL_INTERVAL;
      cfg_r.poll_limit         <= shtm_pkg::RST_POLL_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== rtl/shtm_sequencer.sv =====
// ----------------------------------------------------------------------------
// shtm_sequencer
// Bus sequencer: one step per tick, driving clock and data levels, timing the
// conversion wait and polling, and shifting in the two-byte reading.
// ----------------------------------------------------------------------------
module shtm_sequencer #(
  parameter int unsigned RESET_CLOCKS = 10,
  parameter int unsigned SETTLE_MS    = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  logic [1:0]          func,
  input  logic                data_in,
  input  shtm_pkg::cfg_t      cfg,
  output shtm_pkg::result_t   res
);

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_RST_HI    = 5'd1,
    PH_RST_LO    = 5'd2,
    PH_TS1       = 5'd3,
    PH_TS2       = 5'd4,
    PH_TS3       = 5'd5,
    PH_TS4       = 5'd6,
    PH_TS5       = 5'd7,
    PH_TS6       = 5'd8,
    PH_CMD_LO    = 5'd9,
    PH_CMD_HI    = 5'd10,
    PH_ACK_REL   = 5'd11,
    PH_ACK_HI    = 5'd12,
    PH_ACK_LO    = 5'd13,
    PH_CONV      = 5'd14,
    PH_POLL      = 5'd15,
    PH_POLL_WAIT = 5'd16,
    PH_RD_HI     = 5'd17,
    PH_RD_LO     = 5'd18,
    PH_RA1       = 5'd19,
    PH_RA2       = 5'd20,
    PH_RA3       = 5'd21,
    PH_RA4       = 5'd22,
    PH_SETTLE    = 5'd23
  } phase_t;

  // what the command in flight is for, kept in the shift word while sending
  localparam logic [15:0] PURP_MEAS    = 16'd0;
  localparam logic [15:0] PURP_REINIT  = 16'd1;
  localparam logic [15:0] PURP_RECOVER = 16'd2;
  localparam logic [15:0] PURP_NO_ACK  = 16'd3;

  phase_t      phase_r, phase_nxt;
  logic [4:0]  bc_r, bc_nxt;
  logic [15:0] sw_r, sw_nxt;
  logic [4:0]  cmd_r, cmd_nxt;
  logic [15:0] presc_r, presc_nxt;
  logic [7:0]  ms_r, ms_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        hum_r, hum_nxt;

  logic [15:0] lim;
  logic [15:0] presc_inc;
  logic        presc_roll;
  logic [7:0]  wait_tgt;
  logic        wait_hit;
  logic [15:0] wait_presc;
  logic [7:0]  wait_ms;
  logic [7:0]  cmd_word;
  logic [4:0]  bc_inc;

  // shared millisecond timer
  always_comb begin
    lim        = (cfg.ticks_per_ms == 16'd0) ? 16'd1 : cfg.ticks_per_ms;
    presc_inc  = presc_r + 16'd1;
    presc_roll = (presc_inc >= lim);
    wait_presc = presc_roll ? 16'd0 : presc_inc;
    wait_ms    = presc_roll ? (ms_r + 8'd1) : ms_r;
    case (phase_r)
      PH_CONV:      wait_tgt = hum_r ? cfg.humid_wait_ms : cfg.temp_wait_ms;
      PH_POLL_WAIT: wait_tgt = cfg.poll_interval_ms;
      default:      wait_tgt = 8'(SETTLE_MS);
    endcase
    wait_hit = (ms_r >= wait_tgt);
  end

  assign cmd_word = {3'b000, cmd_r};
  assign bc_inc   = bc_r + 5'd1;

  always_comb begin
    phase_nxt = phase_r;
    bc_nxt    = bc_r;
    sw_nxt    = sw_r;
    cmd_nxt   = cmd_r;
    presc_nxt = presc_r;
    ms_nxt    = ms_r;
    poll_nxt  = poll_r;
    hum_nxt   = hum_r;
    res       = '0;
    res.data_release = 1'b1;

    unique case (phase_r)
      PH_RST_HI: begin
        res.clock_level = 1'b1;
        phase_nxt = PH_RST_LO;
      end
      PH_RST_LO: begin
        bc_nxt    = bc_inc;
        phase_nxt = (bc_inc >= 5'(RESET_CLOCKS)) ? PH_TS1 : PH_RST_HI;
      end
      PH_TS1: begin
        res.clock_level = 1'b1;
        phase_nxt = PH_TS2;
      end
      PH_TS2: begin
        res.clock_level  = 1'b1;
        res.data_release = 1'b0;
        phase_nxt = PH_TS3;
      end
      PH_TS3: begin
        res.data_release = 1'b0;
        phase_nxt = PH_TS4;
      end
      PH_TS4: begin
        res.clock_level  = 1'b1;
        res.data_release = 1'b0;
        phase_nxt = PH_TS5;
      end
      PH_TS5: begin
        res.clock_level = 1'b1;
        phase_nxt = PH_TS6;
      end
      PH_TS6: begin
        bc_nxt    = 5'd0;
        phase_nxt = PH_CMD_LO;
      end
      PH_CMD_LO: begin
        // three leading address zeros fall out of the upper bits of cmd_word
        res.data_release = cmd_word[3'd7 - bc_r[2:0]];
        phase_nxt = PH_CMD_HI;
      end
      PH_CMD_HI: begin
        res.data_release = cmd_word[3'd7 - bc_r[2:0]];
        res.clock_level  = 1'b1;
        bc_nxt    = bc_inc;
        phase_nxt = (bc_inc >= 5'd8) ? PH_ACK_REL : PH_CMD_LO;
      end
      PH_ACK_REL: begin
        phase_nxt = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        res.clock_level = 1'b1;
        if (sw_r == PURP_MEAS && data_in) begin
          sw_nxt = PURP_NO_ACK;
        end
        phase_nxt = PH_ACK_LO;
      end
      PH_ACK_LO: begin
        if (sw_r == PURP_NO_ACK) begin
          res.done_res = 1'b1;
          res.status   = shtm_pkg::STAT_NO_ACK;
          sw_nxt    = 16'd0;
          phase_nxt = PH_IDLE;
        end else begin
          presc_nxt = 16'd0;
          ms_nxt    = 8'd0;
          phase_nxt = (sw_r == PURP_MEAS) ? PH_CONV : PH_SETTLE;
        end
      end
      PH_CONV: begin
        if (wait_hit) begin
          presc_nxt = 16'd0;
          ms_nxt    = 8'd0;
          poll_nxt  = 8'd0;
          phase_nxt = PH_POLL;
        end else begin
          presc_nxt = wait_presc;
          ms_nxt    = wait_ms;
        end
      end
      PH_POLL: begin
        if (!data_in) begin
          sw_nxt    = 16'd0;
          bc_nxt    = 5'd0;
          phase_nxt = PH_RD_HI;
        end else if (poll_r >= cfg.poll_limit) begin
          cmd_nxt   = cfg.soft_reset_command;
          sw_nxt    = PURP_RECOVER;
          bc_nxt    = 5'd0;
          phase_nxt = PH_RST_HI;
        end else begin
          poll_nxt  = poll_r + 8'd1;
          presc_nxt = 16'd0;
          ms_nxt    = 8'd0;
          phase_nxt = PH_POLL_WAIT;
        end
      end
      PH_POLL_WAIT: begin
        if (wait_hit) begin
          presc_nxt = 16'd0;
          ms_nxt    = 8'd0;
          phase_nxt = PH_POLL;
        end else begin
          presc_nxt = wait_presc;
          ms_nxt    = wait_ms;
        end
      end
      PH_RD_HI: begin
        res.clock_level = 1'b1;
        sw_nxt    = {sw_r[14:0], data_in};
        phase_nxt = PH_RD_LO;
      end
      PH_RD_LO: begin
        bc_nxt = bc_inc;
        if (bc_inc >= 5'd16) begin
          res.done_res = 1'b1;
          res.value    = sw_r;
          res.status   = shtm_pkg::STAT_OK;
          sw_nxt    = 16'd0;
          phase_nxt = PH_IDLE;
        end else begin
          phase_nxt = (bc_inc == 5'd8) ? PH_RA1 : PH_RD_HI;
        end
      end
      // master acknowledge after the high byte
      PH_RA1: begin
        res.data_release = 1'b0;
        phase_nxt = PH_RA2;
      end
      PH_RA2: begin
        res.clock_level  = 1'b1;
        res.data_release = 1'b0;
        phase_nxt = PH_RA3;
      end
      PH_RA3: begin
        res.data_release = 1'b0;
        phase_nxt = PH_RA4;
      end
      PH_RA4: begin
        phase_nxt = PH_RD_HI;
      end
      PH_SETTLE: begin
        if (wait_hit) begin
          presc_nxt = 16'd0;
          ms_nxt    = 8'd0;
          if (sw_r == PURP_RECOVER) begin
            res.done_res = 1'b1;
            res.status   = shtm_pkg::STAT_TIMEOUT;
          end
          sw_nxt    = 16'd0;
          phase_nxt = PH_IDLE;
        end else begin
          presc_nxt = wait_presc;
          ms_nxt    = wait_ms;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (func == shtm_pkg::FUNC_TEMP || func == shtm_pkg::FUNC_HUMID) begin
          hum_nxt   = (func == shtm_pkg::FUNC_HUMID);
          cmd_nxt   = (func == shtm_pkg::FUNC_HUMID) ? cfg.humid_command
                                                     : cfg.temp_command;
          sw_nxt    = PURP_MEAS;
          bc_nxt    = 5'd0;
          phase_nxt = PH_RST_HI;
        end else if (func == shtm_pkg::FUNC_REINIT) begin
          cmd_nxt   = cfg.soft_reset_command;
          sw_nxt    = PURP_REINIT;
          bc_nxt    = 5'd0;
          phase_nxt = PH_RST_HI;
        end
      end
    endcase

    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      bc_r    <= 5'd0;
      sw_r    <= 16'd0;
      cmd_r   <= 5'd0;
      presc_r <= 16'd0;
      ms_r    <= 8'd0;
      poll_r  <= 8'd0;
      hum_r   <= 1'b0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      bc_r    <= bc_nxt;
      sw_r    <= sw_nxt;
      cmd_r   <= cmd_nxt;
      presc_r <= presc_nxt;
      ms_r    <= ms_nxt;
      poll_r  <= poll_nxt;
      hum_r   <= hum_nxt;
    end
  end

endmodule

// ===== rtl/humidity_temp_sensor_two_wire_master.sv =====
// ----------------------------------------------------------------------------
// humidity_temp_sensor_two_wire_master
// Two-wire bus master for a humidity/temperature sensor, stepped one tick per
// input beat, with one result beat per input beat.
// ----------------------------------------------------------------------------
// an accepted input beat is held in the input register, then its result in the result register
// throughput: one beat per cycle while the result side does not stall; the sequencer step is a single registered pass
// backpressure on the result side stalls the input register, never drops beats
// reset (rst_n low, synchronous): sequencer back to idle, both pipeline
// registers emptied, configuration registers back to their defaults
module humidity_temp_sensor_two_wire_master #(
  parameter int unsigned RESET_CLOCKS = 10,
  parameter int unsigned SETTLE_MS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] func, [2] data_in, [7:3] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] clock_level, [1] data_release, [2] busy_res,
                                  // [3] done_res, [19:4] value, [21:20] status,
                                  // [23:22] zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  shtm_pkg::cfg_t    cfg;
  shtm_pkg::result_t step_res;
  shtm_pkg::result_t res_r;

  logic       in_valid_r;
  logic [1:0] func_r;
  logic       din_r;
  logic       out_valid_r;
  logic       advance;

  // the input beat moves on whenever the result register is free or draining
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      func_r <= in_tdata[1:0];
      din_r  <= in_tdata[2];
    end
    if (advance) begin
      res_r <= step_res;
    end
  end

  shtm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  shtm_sequencer #(
    .RESET_CLOCKS (RESET_CLOCKS),
    .SETTLE_MS    (SETTLE_MS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .func    (func_r),
    .data_in (din_r),
    .cfg     (cfg),
    .res     (step_res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, res_r};

endmodule

// ===== rtl/shtm_checker.sv =====
// ----------------------------------------------------------------------------
// shtm_checker
// Port-level checks on the result stream of the two-wire sensor master.
// ----------------------------------------------------------------------------
module shtm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  // value and status only carry anything on a done beat
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[21:4] == 18'd0)
    else $error("value or status set without done");

  // failed measurements report no reading
  a_err_val: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] && out_tdata[21:20] != shtm_pkg::STAT_OK
      |-> out_tdata[19:4] == 16'd0)
    else $error("reading reported with an error status");

  // every sequence that reports done has gone idle on that tick, with a defined status
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2] && out_tdata[21:20] != 2'd3)
    else $error("done while still busy or bad status");

endmodule

bind humidity_temp_sensor_two_wire_master shtm_checker u_shtm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== tb/shtm_bus_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// shtm_bus_checker
// Watches the input, result and register channels of the sensor master. It
// steps its own copy of the bus sequencer once per input beat and compares
// every result beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module shtm_bus_checker #(
  parameter int unsigned RESET_CLOCKS = 10,
  parameter int unsigned SETTLE_MS    = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [1:0] func, [2] data_in, [7:3] zero
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [0] clock_level, [1] data_release, [2] busy_res,
                                  // [3] done_res, [19:4] value, [21:20] status
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int unsigned fail_count,
  output int unsigned open_count
);

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_RST_HI, SQ_RST_LO,
    SQ_START1, SQ_START2, SQ_START3, SQ_START4, SQ_START5, SQ_START6,
    SQ_CMD_LO, SQ_CMD_HI, SQ_ACK_REL, SQ_ACK_HI, SQ_ACK_LO,
    SQ_CONVERT, SQ_POLL, SQ_POLL_WAIT, SQ_READ_HI, SQ_READ_LO,
    SQ_MACK1, SQ_MACK2, SQ_MACK3, SQ_MACK4, SQ_SETTLE
  } seq_phase_t;

  // why the current command is on the bus
  typedef enum logic [1:0] {
    JOB_MEASURE, JOB_REINIT, JOB_RECOVER, JOB_NACKED
  } bus_job_t;

  shtm_pkg::cfg_t regs;
  seq_phase_t phase;
  bus_job_t   job;
  logic [4:0] bit_cnt;
  logic [4:0] cmd_word;
  logic [15:0] rx_word;
  logic [15:0] presc;
  logic [7:0] ms_cnt;
  logic [7:0] poll_cnt;
  logic       humid_sel;

  shtm_pkg::result_t reading_q[$];

  function automatic bit wait_elapsed(input int unsigned target);
    logic [15:0] lim;
    lim = (regs.ticks_per_ms == 16'd0) ? 16'd1 : regs.ticks_per_ms;
    if (ms_cnt >= target) begin
      presc  = '0;
      ms_cnt = '0;
      return 1'b1;
    end
    presc = presc + 16'd1;
    if (presc >= lim) begin
      presc  = '0;
      ms_cnt = ms_cnt + 8'd1;
    end
    return 1'b0;
  endfunction

  task automatic start_job(input logic [4:0] code, input bus_job_t why);
    cmd_word = code;
    job      = why;
    bit_cnt  = '0;
    phase    = SQ_RST_HI;
  endtask

  task automatic step_sequencer(input logic [1:0] req, input logic line,
                                output shtm_pkg::result_t r);
    logic [7:0] frame;
    logic [2:0] pos;
    r = '0;
    r.data_release = 1'b1;
    case (phase)
      SQ_RST_HI: begin
        r.clock_level = 1'b1;
        phase = SQ_RST_LO;
      end
      SQ_RST_LO: begin
        bit_cnt = bit_cnt + 5'd1;
        phase = (bit_cnt >= RESET_CLOCKS) ? SQ_START1 : SQ_RST_HI;
      end
      SQ_START1: begin
        r.clock_level = 1'b1;
        phase = SQ_START2;
      end
      SQ_START2: begin
        r.clock_level = 1'b1;
        r.data_release = 1'b0;
        phase = SQ_START3;
      end
      SQ_START3: begin
        r.data_release = 1'b0;
        phase = SQ_START4;
      end
      SQ_START4: begin
        r.clock_level = 1'b1;
        r.data_release = 1'b0;
        phase = SQ_START5;
      end
      SQ_START5: begin
        r.clock_level = 1'b1;
        phase = SQ_START6;
      end
      SQ_START6: begin
        bit_cnt = '0;
        phase = SQ_CMD_LO;
      end
      SQ_CMD_LO, SQ_CMD_HI: begin
        // three address zeros then the command, msb first
        frame = {3'b000, cmd_word};
        pos = 3'd7 - bit_cnt[2:0];
        r.data_release = frame[pos];
        if (phase == SQ_CMD_HI) begin
          r.clock_level = 1'b1;
          bit_cnt = bit_cnt + 5'd1;
          phase = (bit_cnt >= 5'd8) ? SQ_ACK_REL : SQ_CMD_LO;
        end else begin
          phase = SQ_CMD_HI;
        end
      end
      SQ_ACK_REL: phase = SQ_ACK_HI;
      SQ_ACK_HI: begin
        r.clock_level = 1'b1;
        if (job == JOB_MEASURE && line) job = JOB_NACKED;
        phase = SQ_ACK_LO;
      end
      SQ_ACK_LO: begin
        if (job == JOB_NACKED) begin
          r.done_res = 1'b1;
          r.status = shtm_pkg::STAT_NO_ACK;
          job = JOB_MEASURE;
          phase = SQ_IDLE;
        end else begin
          presc = '0;
          ms_cnt = '0;
          phase = (job == JOB_MEASURE) ? SQ_CONVERT : SQ_SETTLE;
        end
      end
      SQ_CONVERT: begin
        if (wait_elapsed(humid_sel ? regs.humid_wait_ms : regs.temp_wait_ms)) begin
          poll_cnt = '0;
          phase = SQ_POLL;
        end
      end
      SQ_POLL: begin
        if (!line) begin
          rx_word = '0;
          bit_cnt = '0;
          phase = SQ_READ_HI;
        end else if (poll_cnt >= regs.poll_limit) begin
          start_job(regs.soft_reset_command, JOB_RECOVER);
        end else begin
          poll_cnt = poll_cnt + 8'd1;
          presc = '0;
          ms_cnt = '0;
          phase = SQ_POLL_WAIT;
        end
      end
      SQ_POLL_WAIT: begin
        if (wait_elapsed(regs.poll_interval_ms)) phase = SQ_POLL;
      end
      SQ_READ_HI: begin
        r.clock_level = 1'b1;
        rx_word = {rx_word[14:0], line};
        phase = SQ_READ_LO;
      end
      SQ_READ_LO: begin
        bit_cnt = bit_cnt + 5'd1;
        if (bit_cnt >= 5'd16) begin
          r.done_res = 1'b1;
          r.value = rx_word;
          r.status = shtm_pkg::STAT_OK;
          rx_word = '0;
          phase = SQ_IDLE;
        end else begin
          phase = (bit_cnt == 5'd8) ? SQ_MACK1 : SQ_READ_HI;
        end
      end
      // master acknowledge after the high byte
      SQ_MACK1: begin
        r.data_release = 1'b0;
        phase = SQ_MACK2;
      end
      SQ_MACK2: begin
        r.clock_level = 1'b1;
        r.data_release = 1'b0;
        phase = SQ_MACK3;
      end
      SQ_MACK3: begin
        r.data_release = 1'b0;
        phase = SQ_MACK4;
      end
      SQ_MACK4: phase = SQ_READ_HI;
      SQ_SETTLE: begin
        if (wait_elapsed(SETTLE_MS)) begin
          if (job == JOB_RECOVER) begin
            r.done_res = 1'b1;
            r.status = shtm_pkg::STAT_TIMEOUT;
          end
          job = JOB_MEASURE;
          phase = SQ_IDLE;
        end
      end
      default: begin
        phase = SQ_IDLE;
        if (req == shtm_pkg::FUNC_TEMP || req == shtm_pkg::FUNC_HUMID) begin
          humid_sel = (req == shtm_pkg::FUNC_HUMID);
          start_job(humid_sel ? regs.humid_command : regs.temp_command, JOB_MEASURE);
        end else if (req == shtm_pkg::FUNC_REINIT) begin
          start_job(regs.soft_reset_command, JOB_REINIT);
        end
      end
    endcase
    r.busy_res = (phase != SQ_IDLE);
  endtask

  always @(posedge clk) begin
    shtm_pkg::result_t want;
    shtm_pkg::result_t got;
    if (!rst_n) begin
      regs.temp_command       = shtm_pkg::RST_TEMP_CMD;
      regs.humid_command      = shtm_pkg::RST_HUMID_CMD;
      regs.soft_reset_command = shtm_pkg::RST_SOFT_RST_CMD;
      regs.ticks_per_ms       = shtm_pkg::RST_TICKS_PER_MS;
      regs.temp_wait_ms       = shtm_pkg::RST_TEMP_WAIT;
      regs.humid_wait_ms      = shtm_pkg::RST_HUMID_WAIT;
      regs.poll_interval_ms   = shtm_pkg::RST_POLL_INTERVAL;
      regs.poll_limit         = shtm_pkg::RST_POLL_LIMIT;
      phase     = SQ_IDLE;
      job       = JOB_MEASURE;
      bit_cnt   = '0;
      cmd_word  = '0;
      rx_word   = '0;
      presc     = '0;
      ms_cnt    = '0;
      poll_cnt  = '0;
      humid_sel = 1'b0;
      reading_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          shtm_pkg::REG_TEMP_CMD:      regs.temp_command       = cfg_data[4:0];
          shtm_pkg::REG_HUMID_CMD:     regs.humid_command      = cfg_data[4:0];
          shtm_pkg::REG_SOFT_RST_CMD:  regs.soft_reset_command = cfg_data[4:0];
          shtm_pkg::REG_TICKS_PER_MS:  regs.ticks_per_ms       = cfg_data;
          shtm_pkg::REG_TEMP_WAIT:     regs.temp_wait_ms       = cfg_data[7:0];
          shtm_pkg::REG_HUMID_WAIT:    regs.humid_wait_ms      = cfg_data[7:0];
          shtm_pkg::REG_POLL_INTERVAL: regs.poll_interval_ms   = cfg_data[7:0];
          shtm_pkg::REG_POLL_LIMIT:    regs.poll_limit         = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got = shtm_pkg::result_t'(out_tdata[21:0]);
        if (reading_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with nothing predicted: %h", $time, out_tdata);
          fail_count++;
        end else begin
          want = reading_q.pop_front();
          if (got.clock_level !== want.clock_level || got.data_release !== want.data_release ||
              got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
              got.value !== want.value || got.status !== want.status) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch, expected clk=%0d rel=%0d busy=%0d done=%0d %s",
                       $time, want.clock_level, want.data_release, want.busy_res,
                       want.done_res, "");
              $display("  expected value=%h status=%0d", want.value, want.status);
              $display("  got clk=%0d rel=%0d busy=%0d done=%0d value=%h status=%0d",
                       got.clock_level, got.data_release, got.busy_res,
                       got.done_res, got.value, got.status);
            end
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        step_sequencer(in_tdata[1:0], in_tdata[2], want);
        reading_q.push_back(want);
      end
    end
    open_count = reading_q.size();
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the two-wire sensor master with bus ticks, start requests and
// random data line levels under several register settings, with random
// gaps and long stalls on both channels; the checker judges every result.
// ----------------------------------------------------------------------------
module tb;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;     // [1:0] func, [2] data_in, [7:3] zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [0] clock_level, [1] data_release, [2] busy_res,
                                  // [3] done_res, [19:4] value, [21:20] status
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int unsigned fail_count;
  int unsigned open_count;
  int unsigned in_beats = 0;
  int unsigned out_beats = 0;
  bit          sender_calm = 1'b0;
  int unsigned low_pct = 50;

  humidity_temp_sensor_two_wire_master dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  shtm_bus_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .open_count(open_count)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (in_tvalid && in_tready) in_beats <= in_beats + 1;
    if (out_tvalid && out_tready) out_beats <= out_beats + 1;
  end

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic offer_beat(input logic [1:0] req, input logic line);
    int unsigned gap;
    gap = pick_gap(sender_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b00000, line, req};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop offering, wait for every reading, then load a full register set
  task automatic reprogram(input logic [4:0] tc, input logic [4:0] hc, input logic [4:0] sc,
                           input logic [15:0] tpm, input logic [7:0] tw,
                           input logic [7:0] hw, input logic [7:0] pi, input logic [7:0] pl);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (out_beats != in_beats);
    repeat (4) @(posedge clk);
    write_reg(shtm_pkg::REG_TEMP_CMD, {11'd0, tc});
    write_reg(shtm_pkg::REG_HUMID_CMD, {11'd0, hc});
    write_reg(shtm_pkg::REG_SOFT_RST_CMD, {11'd0, sc});
    write_reg(shtm_pkg::REG_TICKS_PER_MS, tpm);
    write_reg(shtm_pkg::REG_TEMP_WAIT, {8'd0, tw});
    write_reg(shtm_pkg::REG_HUMID_WAIT, {8'd0, hw});
    write_reg(shtm_pkg::REG_POLL_INTERVAL, {8'd0, pi});
    write_reg(shtm_pkg::REG_POLL_LIMIT, {8'd0, pl});
    cfg_valid <= 1'b0;
    sender_calm = ($urandom_range(0, 3) == 0);
  endtask

  task automatic run_ticks(input int unsigned count);
    logic [1:0] req;
    logic       line;
    for (int unsigned k = 0; k < count; k++) begin
      // the sensor's tendency to hold the line low shifts every so often
      if (k % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: low_pct = 10;
          1: low_pct = 50;
          default: low_pct = 90;
        endcase
      end
      req = shtm_pkg::FUNC_TICK;
      if ($urandom_range(0, 99) >= 82) begin
        case ($urandom_range(0, 2))
          0: req = shtm_pkg::FUNC_TEMP;
          1: req = shtm_pkg::FUNC_HUMID;
          default: req = shtm_pkg::FUNC_REINIT;
        endcase
      end
      line = ($urandom_range(0, 99) < low_pct) ? 1'b0 : 1'b1;
      offer_beat(req, line);
    end
  endtask

  initial begin : result_sink
    int unsigned seen;
    int unsigned hold_at;
    int unsigned stall_left;
    int unsigned calm_left;
    bit          calm;
    seen = 0;
    hold_at = 120;
    stall_left = 0;
    calm_left = 0;
    calm = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) seen++;
      if (calm_left == 0) begin
        calm = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(50, 200);
      end else begin
        calm_left--;
      end
      if (seen >= hold_at) begin
        // long hold-off so the block fills and stalls its input
        hold_at += 400;
        out_tready <= 1'b0;
        repeat (70) @(posedge clk);
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = pick_gap(calm);
      end
    end
  end

  initial begin : stimulus
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle ticks, a start under reset settings, then requests while busy
    offer_beat(shtm_pkg::FUNC_TICK, 1'b0);
    offer_beat(shtm_pkg::FUNC_TICK, 1'b1);
    offer_beat(shtm_pkg::FUNC_TEMP, 1'b1);
    offer_beat(shtm_pkg::FUNC_HUMID, 1'b0);
    offer_beat(shtm_pkg::FUNC_REINIT, 1'b1);
    offer_beat(shtm_pkg::FUNC_TEMP, 1'b0);
    for (int i = 0; i < 14; i++) offer_beat(shtm_pkg::FUNC_TICK, i[0]);

    // zero waits, intervals and poll limit
    reprogram(5'd0, 5'd31, 5'd0, 16'd1, 8'd0, 8'd0, 8'd0, 8'd0);
    run_ticks(170);
    // zero ticks per millisecond
    reprogram(5'd31, 5'd0, 5'd31, 16'd0, 8'd2, 8'd1, 8'd1, 8'd1);
    run_ticks(170);
    reprogram(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
              5'($urandom_range(0, 31)), 16'd2, 8'd3, 8'd2, 8'd2, 8'd255);
    run_ticks(150);
    // top of every timing range; only a short stretch fits
    reprogram(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
              5'($urandom_range(0, 31)), 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255);
    run_ticks(40);
    for (int p = 0; p < 2; p++) begin
      reprogram(5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
                5'($urandom_range(0, 31)), 16'($urandom_range(1, 3)),
                8'($urandom_range(0, 4)), 8'($urandom_range(0, 4)),
                8'($urandom_range(0, 3)), 8'($urandom_range(0, 4)));
      run_ticks(110);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (out_beats != in_beats);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && open_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
